[src/sarw_pkg.sv]
// Shared types and constants for the selective-ack receiver window.
`default_nettype none

package sarw_pkg;

  localparam int SEQ_W = 32;
  localparam int MAP_W = 31;
  localparam int WIN_W = 6;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [MAP_W-1:0] map_t;
  typedef logic [WIN_W-1:0] win_t;

  // window size after reset
  localparam win_t WIN_RESET = 6'd8;

  // next window state and flags for one segment
  typedef struct packed {
    seq_t next_expected;
    map_t next_held;
    logic store;
    logic advanced;
  } calc_result_t;

endpackage

`default_nettype wire

[src/sarw_in_stage.sv]
// Input register for arriving segment sequence numbers.
`default_nettype none

module sarw_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          seg_valid,
  output logic               seg_ready,
  input  wire sarw_pkg::seq_t segment_seq,
  input  wire logic          take,
  output logic               full,
  output sarw_pkg::seq_t     seq
);

  // accept when empty or when the held beat moves on this cycle
  assign seg_ready = !full || take;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (seg_valid && seg_ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (seg_valid && seg_ready) begin
      seq <= segment_seq;
    end
  end

endmodule

`default_nettype wire

[src/sarw_window_calc.sv]
// Window update logic: distance check, bitmap set, trailing-ones advance.
`default_nettype none

module sarw_window_calc #(
  parameter int MAX_WINDOW = 32
) (
  input  wire sarw_pkg::seq_t       segment_seq,
  input  wire sarw_pkg::seq_t       expected_seq,
  input  wire sarw_pkg::map_t       held_bitmap,
  input  wire sarw_pkg::win_t       window_size,
  output sarw_pkg::calc_result_t    result
);

  localparam int WIN_CAP = (MAX_WINDOW < 32) ? MAX_WINDOW : 32;
  localparam sarw_pkg::win_t WIN_CAP_W = sarw_pkg::win_t'(WIN_CAP);

  sarw_pkg::win_t win_eff;
  sarw_pkg::seq_t seg_gap;
  sarw_pkg::map_t run_mask;
  logic [31:0]    run_bits;
  logic [31:0]    first_zero;
  logic [4:0]     run_len;
  sarw_pkg::win_t adv;
  logic [31:0]    shifted;
  logic [4:0]     bit_idx;
  logic           in_window;

  // clamp window to 1..cap
  always_comb begin
    if (window_size == '0) begin
      win_eff = 6'd1;
    end else if (window_size > WIN_CAP_W) begin
      win_eff = WIN_CAP_W;
    end else begin
      win_eff = window_size;
    end
  end

  assign seg_gap = segment_seq - expected_seq;

  // only bits below win_eff - 1 count toward the run
  always_comb begin
    for (int i = 0; i < sarw_pkg::MAP_W; i++) begin
      run_mask[i] = (sarw_pkg::win_t'(i) + 6'd1) < win_eff;
    end
  end

  // lowest clear bit marks the run length
  assign run_bits   = {1'b0, held_bitmap & run_mask};
  assign first_zero = ~run_bits & (run_bits + 32'd1);

  // one-hot to index
  always_comb begin
    run_len = '0;
    for (int j = 0; j < 32; j++) begin
      run_len = run_len | (first_zero[j] ? 5'(j) : 5'd0);
    end
  end

  assign adv     = {1'b0, run_len} + 6'd1;
  assign shifted = ({1'b0, held_bitmap} >> run_len) >> 1;

  assign in_window = (seg_gap != '0) && (seg_gap < 32'(win_eff));
  assign bit_idx   = seg_gap[4:0] - 5'd1;

  // select the update
  always_comb begin
    result.next_expected = expected_seq;
    result.next_held     = held_bitmap;
    result.store         = 1'b0;
    result.advanced      = 1'b0;
    if (seg_gap == '0) begin
      result.next_expected = expected_seq + 32'(adv);
      result.next_held     = shifted[30:0];
      result.store         = 1'b1;
      result.advanced      = 1'b1;
    end else if (in_window) begin
      result.next_held = held_bitmap | (sarw_pkg::map_t'(1) << bit_idx);
      result.store     = 1'b1;
    end
  end

endmodule

`default_nettype wire

[src/selective_ack_receiver_window.sv]
// Top level of the selective-repeat receiver window with SACK bitmap.
//
//  channel | signals                                     | dir
//  --------+---------------------------------------------+-----
//  seg     | seg_valid, seg_ready, segment_seq           | in
//  ack     | ack_valid, ack_ready, ack_seq, sack_bitmap, | out
//          | store_payload, advanced                     |
//  cfg     | cfg_valid, cfg_ready, cfg_data              | in
//
// One segment per cycle sustained while ack_ready holds; a seg beat passes the
// input register, then window logic into the output register, to the ack beat.
// The window state updates when a segment moves into the output register,
// so the next segment in the input register sees the updated state.
// Reset clears expected sequence and bitmap and sets window size to 8.
// A stalled ack holds its beat; the input register keeps taking one more segment.
`default_nettype none

module selective_ack_receiver_window #(
  parameter int MAX_WINDOW = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           seg_valid,
  output logic                seg_ready,
  input  wire sarw_pkg::seq_t segment_seq,
  output logic                ack_valid,
  input  wire logic           ack_ready,
  output sarw_pkg::seq_t      ack_seq,
  output sarw_pkg::map_t      sack_bitmap,
  output logic                store_payload,
  output logic                advanced,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire sarw_pkg::win_t cfg_data
);

  sarw_pkg::seq_t        expected_seq;
  sarw_pkg::map_t        held_bitmap;
  sarw_pkg::win_t        window_size;
  logic                  in_full;
  sarw_pkg::seq_t        in_seq;
  logic                  take;
  sarw_pkg::calc_result_t calc;

  assign cfg_ready = 1'b1;

  // move a segment when the output register is free or draining
  assign take = in_full && (!ack_valid || ack_ready);

  sarw_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .seg_valid   (seg_valid),
    .seg_ready   (seg_ready),
    .segment_seq (segment_seq),
    .take        (take),
    .full        (in_full),
    .seq         (in_seq)
  );

  sarw_window_calc #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_calc (
    .segment_seq  (in_seq),
    .expected_seq (expected_seq),
    .held_bitmap  (held_bitmap),
    .window_size  (window_size),
    .result       (calc)
  );

  // window state and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq <= '0;
      held_bitmap  <= '0;
      window_size  <= sarw_pkg::WIN_RESET;
    end else begin
      if (take) begin
        expected_seq <= calc.next_expected;
        held_bitmap  <= calc.next_held;
      end
      if (cfg_valid && cfg_ready) begin
        window_size <= cfg_data;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_valid <= 1'b0;
    end else if (take) begin
      ack_valid <= 1'b1;
    end else if (ack_ready) begin
      ack_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (take) begin
      ack_seq       <= calc.next_expected;
      sack_bitmap   <= calc.next_held;
      store_payload <= calc.store;
      advanced      <= calc.advanced;
    end
  end

  // an advance always stores the segment
  a_adv_stores: assert property (@(posedge clk) disable iff (rst)
    ack_valid |-> (!advanced || store_payload))
    else $error("advance without store");

  // an advance moves the expected sequence
  a_adv_moves: assert property (@(posedge clk) disable iff (rst)
    (take && calc.advanced) |=> (expected_seq != $past(expected_seq)))
    else $error("advance left expected sequence unchanged");

  // state holds when no segment moves
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !take |=> ($stable(expected_seq) && $stable(held_bitmap)))
    else $error("window state changed without a segment");

  // a segment that does not advance never clears held bits
  a_no_clear: assert property (@(posedge clk) disable iff (rst)
    (take && !calc.advanced) |=> (($past(held_bitmap) & ~held_bitmap) == '0))
    else $error("held bit cleared without advance");

  // the ack beat carries the state just written
  a_ack_state: assert property (@(posedge clk) disable iff (rst)
    take |=> (ack_seq == expected_seq && sack_bitmap == held_bitmap))
    else $error("ack differs from window state");

endmodule

`default_nettype wire
